// ----- sv/bcdalm_pkg.sv -----
`default_nettype none

package bcdalm_pkg;

    // prescaler width, the tick rate register is zero-extended or truncated to it
    localparam int PRESCALE_WIDTH = 16;

    // width of the tick rate register
    localparam int TPS_WIDTH = 16;
    localparam logic [TPS_WIDTH-1:0] TPS_RESET = 16'd1000;

    localparam int N_TIME_DIGITS  = 6;
    localparam int N_ALARM_DIGITS = 4;

    // operation codes
    localparam logic [1:0] FUNC_TICK      = 2'd0;
    localparam logic [1:0] FUNC_SET_TIME  = 2'd1;
    localparam logic [1:0] FUNC_SET_ALARM = 2'd2;
    localparam logic [1:0] FUNC_TOGGLE    = 2'd3;

    typedef logic [3:0] t_digit;

    localparam t_digit DIGIT_MAX = 4'd9;

    // wrap limits, hour tens first
    localparam t_digit [0:N_TIME_DIGITS-1] DIGIT_LIMIT =
        {4'd10, 4'd10, 4'd6, 4'd10, 4'd6, 4'd10};

    typedef struct packed {
        logic [1:0]                    func;
        logic [2:0]                    digit_count;
        t_digit [0:N_TIME_DIGITS-1]    dig;
    } t_item;

    typedef struct packed {
        logic [PRESCALE_WIDTH-1:0]     tick_cnt;
        t_digit [0:N_TIME_DIGITS-1]    tm;
        t_digit [0:N_ALARM_DIGITS-1]   al;
        logic                          time_vld;
        logic                          alarm_en;
    } t_state;

    typedef struct packed {
        logic                          alarm_event;
        logic                          time_valid;
        logic                          alarm_enabled;
        t_digit [0:N_TIME_DIGITS-1]    tm;
        t_digit [0:N_ALARM_DIGITS-1]   al;
    } t_result;

    function automatic t_digit sat_digit(input t_digit d);
        return (d > DIGIT_MAX) ? DIGIT_MAX : d;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bcdalm_in_stage.sv -----
`default_nettype none

module bcdalm_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire bcdalm_pkg::t_item i_item,
    input  wire logic              i_take,
    output logic                   o_stall,
    output logic                   o_vld,
    output bcdalm_pkg::t_item      o_item
);

    logic              r_vld;
    bcdalm_pkg::t_item r_item;
    logic              n_vld;

    // holding register is full and the step logic cannot take it
    assign o_stall = r_vld && !i_take;

    always_comb begin
        n_vld = r_vld;
        if (!o_stall) begin
            n_vld = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

// ----- sv/bcdalm_step.sv -----
`default_nettype none

module bcdalm_step (
    input  wire bcdalm_pkg::t_item                   i_item,
    input  wire bcdalm_pkg::t_state                  i_state,
    input  wire logic [bcdalm_pkg::TPS_WIDTH-1:0]    i_tps,
    output bcdalm_pkg::t_state                       o_state,
    output bcdalm_pkg::t_result                      o_result
);

    localparam int PW = bcdalm_pkg::PRESCALE_WIDTH;
    localparam int TW = bcdalm_pkg::TPS_WIDTH;

    logic [PW+TW-1:0]   tps_ext;
    logic [PW-1:0]      tps_p;
    logic [PW-1:0]      cnt_inc;
    logic               fire;
    logic               carry;
    bcdalm_pkg::t_digit dig_inc;
    bcdalm_pkg::t_state n_state;

    assign tps_ext = {{PW{1'b0}}, i_tps};
    assign tps_p   = tps_ext[PW-1:0];
    assign cnt_inc = i_state.tick_cnt + {{(PW-1){1'b0}}, 1'b1};

    always_comb begin
        n_state = i_state;
        fire    = 1'b0;
        carry   = 1'b1;
        dig_inc = '0;
        case (i_item.func)
            bcdalm_pkg::FUNC_TICK: begin
                n_state.tick_cnt = cnt_inc;
                if (cnt_inc == tps_p) begin
                    n_state.tick_cnt = '0;
                    // ripple from seconds units up to hour tens
                    for (int i = bcdalm_pkg::N_TIME_DIGITS - 1; i >= 0; i--) begin
                        if (carry) begin
                            dig_inc = n_state.tm[i] + 4'd1;
                            if (dig_inc >= bcdalm_pkg::DIGIT_LIMIT[i]) begin
                                n_state.tm[i] = '0;
                                carry = 1'b1;
                            end else begin
                                n_state.tm[i] = dig_inc;
                                carry = 1'b0;
                            end
                        end
                    end
                    // alarm compare sees the hour before the midnight wrap
                    fire = i_state.alarm_en
                        && (n_state.tm[4] == 4'd0) && (n_state.tm[5] == 4'd0)
                        && (n_state.tm[0:3] == i_state.al);
                    if ((n_state.tm[0] == 4'd2) && (n_state.tm[1] == 4'd4)) begin
                        n_state.tm[0] = '0;
                        n_state.tm[1] = '0;
                    end
                end
            end
            bcdalm_pkg::FUNC_SET_TIME: begin
                for (int i = 0; i < bcdalm_pkg::N_TIME_DIGITS; i++) begin
                    if (3'(i) < i_item.digit_count) begin
                        n_state.tm[i] = bcdalm_pkg::sat_digit(i_item.dig[i]);
                    end
                end
                n_state.time_vld = 1'b1;
            end
            bcdalm_pkg::FUNC_SET_ALARM: begin
                for (int i = 0; i < bcdalm_pkg::N_ALARM_DIGITS; i++) begin
                    if (3'(i) < i_item.digit_count) begin
                        n_state.al[i] = bcdalm_pkg::sat_digit(i_item.dig[i]);
                    end
                end
                n_state.alarm_en = 1'b1;
            end
            bcdalm_pkg::FUNC_TOGGLE: begin
                n_state.alarm_en = !i_state.alarm_en;
            end
            default: begin
                n_state = i_state;
            end
        endcase
    end

    assign o_state                = n_state;
    assign o_result.alarm_event   = fire;
    assign o_result.time_valid    = n_state.time_vld;
    assign o_result.alarm_enabled = n_state.alarm_en;
    assign o_result.tm            = n_state.tm;
    assign o_result.al            = n_state.al;

endmodule

`default_nettype wire

// ----- sv/bcd_clock_with_alarm.sv -----
// bcd_clock_with_alarm: 24-hour hh:mm:ss clock in six bcd digits with one hh:mm alarm
//
// input channel: i_in_valid / o_in_stall carry one word per operation
//   (tick, set time, set alarm, toggle alarm enable) with its digit fields
// output channel: o_out_valid / i_out_stall return exactly one word per input
//   word, showing the alarm event and the clock and alarm state after it
// config: i_cfg_wr_en / i_cfg_wr_data load the ticks per second; the user must write
//   them only while idle, as the block itself does not check it
// path: input register, then step logic, into the output register behind o_out_valid
// throughput: one word per cycle while i_out_stall stays low; the clock state lives in
//   flip-flops and the whole digit carry chain plus alarm compare is combinational
// stall: a stalled result holds in the output register while the input
//   register still takes one more word; after that o_in_stall rises until
//   the receiver takes the waiting result
// reset (synchronous, active low): time and alarm digits 00, flags clear,
//   prescaler cleared, ticks per second back to 1000, both channels empty
`default_nettype none

module bcd_clock_with_alarm (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_digit_count,
    input  wire logic [3:0]  i_in_hour_tens,
    input  wire logic [3:0]  i_in_hour_units,
    input  wire logic [3:0]  i_in_minutes_tens,
    input  wire logic [3:0]  i_in_minutes_units,
    input  wire logic [3:0]  i_in_second_tens,
    input  wire logic [3:0]  i_in_second_units,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_alarm_event,
    output logic             o_time_valid,
    output logic             o_alarm_enabled,
    output logic [3:0]       o_hour_tens,
    output logic [3:0]       o_hour_units,
    output logic [3:0]       o_minutes_tens,
    output logic [3:0]       o_minutes_units,
    output logic [3:0]       o_second_tens,
    output logic [3:0]       o_second_units,
    output logic [15:0]      o_alarm_hhmm
);

    bcdalm_pkg::t_item   in_item;
    bcdalm_pkg::t_item   stg_item;
    logic                stg_vld;
    logic                out_free;
    logic                take;

    // ticks per second register
    logic [bcdalm_pkg::TPS_WIDTH-1:0] r_tps;

    // clock state and output register
    bcdalm_pkg::t_state  r_state;
    bcdalm_pkg::t_state  n_state;
    bcdalm_pkg::t_result r_result;
    bcdalm_pkg::t_result n_result;
    logic                r_out_vld;
    logic                n_out_vld;

    assign in_item.func        = i_func;
    assign in_item.digit_count = i_digit_count;
    assign in_item.dig         = {i_in_hour_tens, i_in_hour_units,
                                  i_in_minutes_tens, i_in_minutes_units,
                                  i_in_second_tens, i_in_second_units};

    // output register is free when empty or being drained this cycle
    assign out_free = !r_out_vld || !i_out_stall;
    assign take     = stg_vld && out_free;

    bcdalm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (take),
        .o_stall (o_in_stall),
        .o_vld   (stg_vld),
        .o_item  (stg_item)
    );

    bcdalm_step u_step (
        .i_item   (stg_item),
        .i_state  (r_state),
        .i_tps    (r_tps),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_comb begin
        n_out_vld = r_out_vld;
        if (out_free) begin
            n_out_vld = stg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= bcdalm_pkg::TPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_tps <= i_cfg_wr_data;
        end
    end

    // state advances only when a word moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (take) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_alarm_event   = r_result.alarm_event;
    assign o_time_valid    = r_result.time_valid;
    assign o_alarm_enabled = r_result.alarm_enabled;
    assign o_hour_tens     = r_result.tm[0];
    assign o_hour_units    = r_result.tm[1];
    assign o_minutes_tens  = r_result.tm[2];
    assign o_minutes_units = r_result.tm[3];
    assign o_second_tens   = r_result.tm[4];
    assign o_second_units  = r_result.tm[5];
    // hour tens in the top nibble
    assign o_alarm_hhmm    = r_result.al;

endmodule

`default_nettype wire

// ----- sv/bcdalm_checker.sv -----
`default_nettype none

module bcdalm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_alarm_event,
    input wire logic        o_alarm_enabled,
    input wire logic [3:0]  o_hour_tens,
    input wire logic [3:0]  o_hour_units,
    input wire logic [3:0]  o_minutes_tens,
    input wire logic [3:0]  o_minutes_units,
    input wire logic [3:0]  o_second_tens,
    input wire logic [3:0]  o_second_units,
    input wire logic [15:0] o_alarm_hhmm
);

    logic [15:0] hhmm;

    assign hhmm = {o_hour_tens, o_hour_units, o_minutes_tens, o_minutes_units};

    // both channels come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channel not empty after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hour_tens)
            && $stable(o_second_units) && $stable(o_alarm_hhmm)
            && $stable(o_alarm_event))
        else $error("stalled result word changed");

    // an alarm only fires on an enabled match at the top of a minute
    a_alarm_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alarm_event |-> o_alarm_enabled
            && o_second_tens == 4'd0 && o_second_units == 4'd0
            && (o_alarm_hhmm == hhmm
                || (o_alarm_hhmm[15:8] == 8'h24 && hhmm[15:8] == 8'h00
                    && o_alarm_hhmm[7:0] == hhmm[7:0])))
        else $error("alarm event without matching time");

    // the digits never leave the decimal range
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hour_tens <= 4'd9 && o_hour_units <= 4'd9
            && o_minutes_tens <= 4'd9 && o_minutes_units <= 4'd9
            && o_second_tens <= 4'd9 && o_second_units <= 4'd9
            && o_alarm_hhmm[15:12] <= 4'd9 && o_alarm_hhmm[11:8] <= 4'd9
            && o_alarm_hhmm[7:4] <= 4'd9 && o_alarm_hhmm[3:0] <= 4'd9)
        else $error("digit outside decimal range");

endmodule

bind bcd_clock_with_alarm bcdalm_checker u_bcdalm_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    // wrap limits of the clock digits, seen from the carry chain
    localparam bcdalm_pkg::t_digit UNITS_WRAP = 4'd10;
    localparam bcdalm_pkg::t_digit TENS_WRAP  = 4'd6;
    localparam bcdalm_pkg::t_digit DIGIT_TOP  = 4'd9;

    // no word accepted or returned for this many cycles means the block has hung
    localparam int QUIET_LIMIT = 2000;

    // one result word as the block shows it, hour tens first
    typedef struct packed {
        logic                       alarm_event;
        logic                       time_valid;
        logic                       alarm_enabled;
        bcdalm_pkg::t_digit [0:5]   tm;
        logic [15:0]                alarm_hhmm;
    } t_clock_word;

    localparam t_clock_word NO_WANT = '0;

    // a directed row is either an input word or a tick rate write
    typedef enum logic { ROW_WORD, ROW_TPS } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [15:0]                tps;
        logic [1:0]                 func;
        logic [2:0]                 cnt;
        bcdalm_pkg::t_digit [0:5]   dig;
        logic                       typed;
        t_clock_word                want;
    } t_stim_row;

    localparam int N_ROWS = 23;

    // directed part; typed rows carry their result, the rest go to the predictor
    t_stim_row stim_rows [N_ROWS] = '{
        // straight after reset, ticks per second still at its reset value
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b1,
          '{1'b0, 1'b0, 1'b0, 24'h000000, 16'h0000}},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TOGGLE,    3'd0, 24'h000000, 1'b1,
          '{1'b0, 1'b0, 1'b1, 24'h000000, 16'h0000}},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TOGGLE,    3'd0, 24'h000000, 1'b1,
          '{1'b0, 1'b0, 1'b0, 24'h000000, 16'h0000}},
        // a count of zero copies nothing but still sets the flags
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd0, 24'h123456, 1'b1,
          '{1'b0, 1'b1, 1'b0, 24'h000000, 16'h0000}},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_ALARM, 3'd0, 24'h654321, 1'b1,
          '{1'b0, 1'b1, 1'b1, 24'h000000, 16'h0000}},
        // runs the prescaler out at 1000, then one tick per second
        '{ROW_TPS,  16'd1, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        // digits above nine saturate
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd6, 24'hFFFFFF, 1'b1,
          '{1'b0, 1'b1, 1'b1, 24'h999999, 16'h0000}},
        // every digit past its limit, hour tens wraps with no further carry
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        // counts beyond the digit count are clipped
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd7, 24'h235959, 1'b1,
          '{1'b0, 1'b1, 1'b1, 24'h235959, 16'h0000}},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_ALARM, 3'd7, 24'h240099, 1'b1,
          '{1'b0, 1'b1, 1'b1, 24'h235959, 16'h2400}},
        // alarm at 24:00 fires before the hour wrap
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        // hours above 23 other than 24 keep counting
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd6, 24'h245959, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd2, 24'h09ABCD, 1'b0, NO_WANT},
        // ordinary alarm, enabled and then disabled
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_ALARM, 3'd5, 24'h0901FF, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd6, 24'h090059, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TOGGLE,    3'd0, 24'h000000, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd6, 24'h090059, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd0, 24'h000000, 1'b0, NO_WANT},
        // partial copies with saturation
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_ALARM, 3'd2, 24'hFA0000, 1'b0, NO_WANT},
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_SET_TIME,  3'd4, 24'h5F0000, 1'b0, NO_WANT},
        // a tick ignores its count and digit fields
        '{ROW_WORD, 16'd0, bcdalm_pkg::FUNC_TICK,      3'd7, 24'hFFFFFF, 1'b0, NO_WANT}
    };

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [15:0]    i_cfg_wr_data = '0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    logic [1:0]     i_func = bcdalm_pkg::FUNC_TICK;
    logic [2:0]     i_digit_count = '0;
    logic [3:0]     i_in_hour_tens = '0;
    logic [3:0]     i_in_hour_units = '0;
    logic [3:0]     i_in_minutes_tens = '0;
    logic [3:0]     i_in_minutes_units = '0;
    logic [3:0]     i_in_second_tens = '0;
    logic [3:0]     i_in_second_units = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    logic           o_alarm_event;
    logic           o_time_valid;
    logic           o_alarm_enabled;
    logic [3:0]     o_hour_tens;
    logic [3:0]     o_hour_units;
    logic [3:0]     o_minutes_tens;
    logic [3:0]     o_minutes_units;
    logic [3:0]     o_second_tens;
    logic [3:0]     o_second_units;
    logic [15:0]    o_alarm_hhmm;

    // typed expectation travelling alongside the input word
    logic           word_typed = 1'b0;
    t_clock_word    word_want = NO_WANT;

    // predictor copy of the clock
    logic [15:0]                rtc_tps;
    logic [15:0]                rtc_prescale;
    bcdalm_pkg::t_digit [0:5]   rtc_time;
    bcdalm_pkg::t_digit [0:3]   rtc_alarm;
    logic                       rtc_time_set;
    logic                       rtc_alarm_on;

    t_clock_word    expected_words [$];
    int unsigned    fault_count = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    words_sent = 0;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_stall_pct = 0;
    logic [15:0]    cur_tps = bcdalm_pkg::TPS_RESET;

    bcd_clock_with_alarm dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_digit_count      (i_digit_count),
        .i_in_hour_tens     (i_in_hour_tens),
        .i_in_hour_units    (i_in_hour_units),
        .i_in_minutes_tens  (i_in_minutes_tens),
        .i_in_minutes_units (i_in_minutes_units),
        .i_in_second_tens   (i_in_second_tens),
        .i_in_second_units  (i_in_second_units),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_alarm_event      (o_alarm_event),
        .o_time_valid       (o_time_valid),
        .o_alarm_enabled    (o_alarm_enabled),
        .o_hour_tens        (o_hour_tens),
        .o_hour_units       (o_hour_units),
        .o_minutes_tens     (o_minutes_tens),
        .o_minutes_units    (o_minutes_units),
        .o_second_tens      (o_second_tens),
        .o_second_units     (o_second_units),
        .o_alarm_hhmm       (o_alarm_hhmm)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // applies one input word to the predicted clock and returns the word it shows
    function automatic t_clock_word predict_clock_word(input logic [1:0] func,
                                                       input logic [2:0] cnt,
                                                       input bcdalm_pkg::t_digit [0:5] dig);
        t_clock_word        w;
        logic               fire;
        logic               carry;
        bcdalm_pkg::t_digit nxt;
        int                 i;
        fire = 1'b0;
        case (func)
            bcdalm_pkg::FUNC_TICK: begin
                rtc_prescale = rtc_prescale + 16'd1;
                if (rtc_prescale == rtc_tps) begin
                    rtc_prescale = '0;
                    // carry ripples up from seconds units
                    carry = 1'b1;
                    for (i = 5; i >= 0; i--) begin
                        if (carry) begin
                            nxt = rtc_time[i] + 4'd1;
                            carry = (nxt >= ((i == 2 || i == 4) ? TENS_WRAP : UNITS_WRAP));
                            rtc_time[i] = carry ? 4'd0 : nxt;
                        end
                    end
                    // alarm compare sees 24:00 before it folds back to 00:00
                    fire = rtc_alarm_on && rtc_time[4] == 4'd0 && rtc_time[5] == 4'd0
                           && rtc_time[0:3] == rtc_alarm;
                    if (rtc_time[0] == 4'd2 && rtc_time[1] == 4'd4) begin
                        rtc_time[0] = 4'd0;
                        rtc_time[1] = 4'd0;
                    end
                end
            end
            bcdalm_pkg::FUNC_SET_TIME: begin
                for (i = 0; i < 6; i++) begin
                    if (i < cnt) begin
                        rtc_time[i] = (dig[i] > DIGIT_TOP) ? DIGIT_TOP : dig[i];
                    end
                end
                rtc_time_set = 1'b1;
            end
            bcdalm_pkg::FUNC_SET_ALARM: begin
                for (i = 0; i < 4; i++) begin
                    if (i < cnt) begin
                        rtc_alarm[i] = (dig[i] > DIGIT_TOP) ? DIGIT_TOP : dig[i];
                    end
                end
                rtc_alarm_on = 1'b1;
            end
            default: begin
                rtc_alarm_on = !rtc_alarm_on;
            end
        endcase
        w.alarm_event   = fire;
        w.time_valid    = rtc_time_set;
        w.alarm_enabled = rtc_alarm_on;
        w.tm            = rtc_time;
        w.alarm_hhmm    = rtc_alarm;
        return w;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fault_count++;
        end
    endfunction

    // watches both channels and the register port at every edge
    always @(posedge i_clk) begin
        t_clock_word want;
        t_clock_word got;
        if (!i_rst_n) begin
            rtc_tps      = bcdalm_pkg::TPS_RESET;
            rtc_prescale = '0;
            rtc_time     = '0;
            rtc_alarm    = '0;
            rtc_time_set = 1'b0;
            rtc_alarm_on = 1'b0;
        end else begin
            // results are checked before this edge's input is predicted
            if (o_out_valid && !i_out_stall) begin
                got = {o_alarm_event, o_time_valid, o_alarm_enabled,
                       o_hour_tens, o_hour_units, o_minutes_tens,
                       o_minutes_units, o_second_tens, o_second_units, o_alarm_hhmm};
                if (expected_words.size() == 0) begin
                    $error("result word with no expectation pending");
                    fault_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("alarm_event", want.alarm_event, got.alarm_event);
                    check_field("time_valid", want.time_valid, got.time_valid);
                    check_field("alarm_enabled", want.alarm_enabled, got.alarm_enabled);
                    check_field("hour_tens", want.tm[0], got.tm[0]);
                    check_field("hour_units", want.tm[1], got.tm[1]);
                    check_field("minutes_tens", want.tm[2], got.tm[2]);
                    check_field("minutes_units", want.tm[3], got.tm[3]);
                    check_field("second_tens", want.tm[4], got.tm[4]);
                    check_field("second_units", want.tm[5], got.tm[5]);
                    check_field("alarm_hhmm", want.alarm_hhmm, got.alarm_hhmm);
                end
            end
            if (i_cfg_wr_en) begin
                rtc_tps = i_cfg_wr_data;
            end
            if (i_in_valid && !o_in_stall) begin
                want = predict_clock_word(i_func, i_digit_count,
                                          {i_in_hour_tens, i_in_hour_units,
                                           i_in_minutes_tens, i_in_minutes_units,
                                           i_in_second_tens, i_in_second_units});
                // typed rows override the predictor, which still tracks the state
                expected_words.push_back(word_typed ? word_want : want);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // hang detection
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("bcd_clock_with_alarm test failed");
        $finish;
    end

    // presents one word after a random gap and returns at the edge that takes it;
    // valid stays high so a following word can go out back to back
    task automatic send_word(input logic [1:0] func, input logic [2:0] cnt,
                             input bcdalm_pkg::t_digit [0:5] dig, input logic typed,
                             input t_clock_word want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_func             <= func;
        i_digit_count      <= cnt;
        i_in_hour_tens     <= dig[0];
        i_in_hour_units    <= dig[1];
        i_in_minutes_tens  <= dig[2];
        i_in_minutes_units <= dig[3];
        i_in_second_tens   <= dig[4];
        i_in_second_units  <= dig[5];
        word_typed         <= typed;
        word_want          <= want;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // tick with junk in the fields it ignores
    task automatic send_tick();
        send_word(bcdalm_pkg::FUNC_TICK, 3'($urandom), 24'($urandom), 1'b0, NO_WANT);
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (expected_words.size() != 0);
        @(posedge i_clk);
    endtask

    // ticks a running prescaler round to zero, then loads the tick rate while idle
    task automatic write_tps(input logic [15:0] value);
        int n;
        wait_drained();
        if (rtc_prescale != '0) begin
            n = int'(rtc_tps) - int'(rtc_prescale);
            if (n <= 0) begin
                n += 65536;
            end
            repeat (n) send_tick();
            wait_drained();
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_tps = value;
    endtask

    // mostly alarm approaches and rollovers with random content, some raw noise
    task automatic random_traffic(input int unsigned words);
        int unsigned              stop_at;
        int                       ah, am, d, secs, n, pick;
        bcdalm_pkg::t_digit [0:5] dig;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                // alarm at hh:mm, clock set a few seconds short of it
                ah = $urandom_range(23);
                am = $urandom_range(59);
                if ($urandom_range(7) == 0) begin
                    ah = 24;
                    am = 0;
                end
                dig = 24'($urandom);
                dig[0:3] = {4'(ah / 10), 4'(ah % 10), 4'(am / 10), 4'(am % 10)};
                send_word(bcdalm_pkg::FUNC_SET_ALARM, 3'($urandom_range(4, 7)), dig,
                          1'b0, NO_WANT);
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) send_word(bcdalm_pkg::FUNC_TOGGLE, 3'($urandom), 24'($urandom),
                                     1'b0, NO_WANT);
                d = $urandom_range(1, 3);
                secs = ah * 3600 + am * 60 - d;
                if (secs < 0) begin
                    secs += 86400;
                end
                dig = {4'(secs / 36000), 4'(secs / 3600 % 10), 4'(secs % 3600 / 600),
                       4'(secs % 600 / 60), 4'(secs % 60 / 10), 4'(secs % 10)};
                send_word(bcdalm_pkg::FUNC_SET_TIME, 3'($urandom_range(6, 7)), dig,
                          1'b0, NO_WANT);
                if (cur_tps != 0 && cur_tps <= 8) begin
                    n = d * cur_tps + $urandom_range(0, 2 * cur_tps);
                end else begin
                    n = $urandom_range(1, 6);
                end
                repeat (n) send_tick();
            end else if (pick < 60) begin
                // clock parked just before a carry into the hours
                case ($urandom_range(2))
                    0:       dig = {8'h23, 8'h59, 4'd5, 4'($urandom_range(9))};
                    1:       dig = {4'($urandom_range(2, 9)), 4'($urandom_range(9)),
                                    8'h59, 4'd5, 4'($urandom_range(9))};
                    default: dig = 24'($urandom);
                endcase
                send_word(bcdalm_pkg::FUNC_SET_TIME, 3'($urandom_range(5, 7)), dig,
                          1'b0, NO_WANT);
                if (cur_tps != 0 && cur_tps <= 8) begin
                    n = $urandom_range(1, 12) * cur_tps;
                end else begin
                    n = $urandom_range(1, 6);
                end
                repeat (n) send_tick();
            end else begin
                send_word(2'($urandom), 3'($urandom), 24'($urandom), 1'b0, NO_WANT);
            end
        end
    endtask

    initial begin
        int r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slow sender against a busy receiver
        tx_idle_pct  = 38;
        rx_stall_pct = 67;
        for (r = 0; r < N_ROWS; r++) begin
            if (stim_rows[r].kind == ROW_TPS) begin
                write_tps(stim_rows[r].tps);
            end else begin
                send_word(stim_rows[r].func, stim_rows[r].cnt, stim_rows[r].dig,
                          stim_rows[r].typed, stim_rows[r].want);
            end
        end
        random_traffic(150);

        // the other way round, three ticks to a second
        tx_idle_pct  = 67;
        rx_stall_pct = 38;
        write_tps(16'd3);
        random_traffic(200);

        // flat out, two ticks to a second
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_tps(16'd2);
        random_traffic(150);

        wait_drained();
        // wait for any stray word to show up
        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("bcd_clock_with_alarm test passed");
        end else begin
            $display("bcd_clock_with_alarm test failed");
        end
        $finish;
    end

endmodule
